### src/ffha_pkg.sv
// ffha_pkg: shared constants and control types of the first-fit heap allocator
// depends on nothing; used by the controller, the datapath and the top level
package ffha_pkg;

  localparam int HEAP_WORDS_DEF   = 1024;
  localparam int HEADER_WORDS_DEF = 4;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_SETUP  = 3'd1;
  localparam logic [2:0] WR_USED   = 3'd2;
  localparam logic [2:0] WR_NEW    = 3'd3;
  localparam logic [2:0] WR_LINK_A = 3'd4;
  localparam logic [2:0] WR_FREE   = 3'd5;
  localparam logic [2:0] WR_FIN    = 3'd6;
  localparam logic [2:0] WR_LINK_R = 3'd7;

  localparam logic [1:0] PTR_HOLD  = 2'd0;
  localparam logic [1:0] PTR_NEXT  = 2'd1;
  localparam logic [1:0] PTR_PREV  = 2'd2;
  localparam logic [1:0] PTR_CNEXT = 2'd3;

  typedef struct packed {
    logic       load;
    logic [1:0] ptr_sel;
    logic       cap;
    logic       merge_prev;
    logic       merge_next;
    logic [2:0] wr;
    logic       set_ready;
    logic       res_set;
    logic       res_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic alloc_cmd;
    logic want_zero;
    logic ready;
    logic rel_bad;
    logic fit;
    logic split;
    logic hit;
    logic past;
    logic rfree;
    logic rnext_seg;
    logic cprev_seg;
    logic cnext_seg;
  } dp_stat_t;

endpackage

### src/ffha_ctrl.sv
// ffha_ctrl: sequencing state machine for allocate and release items
// depends on ffha_pkg; drives ffha_dp through dp_cmd_t and reads dp_stat_t
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_cmd_t  dcmd,
  output logic               busy,
  output logic               done
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECIDE = 5'd1;
  localparam logic [4:0] S_SETUP  = 5'd2;
  localparam logic [4:0] S_A_RD   = 5'd3;
  localparam logic [4:0] S_A_EV   = 5'd4;
  localparam logic [4:0] S_A_W1   = 5'd5;
  localparam logic [4:0] S_A_W2   = 5'd6;
  localparam logic [4:0] S_A_W3   = 5'd7;
  localparam logic [4:0] S_W_RD   = 5'd8;
  localparam logic [4:0] S_W_EV   = 5'd9;
  localparam logic [4:0] S_R_FREE = 5'd10;
  localparam logic [4:0] S_R_PRD  = 5'd11;
  localparam logic [4:0] S_R_PEV  = 5'd12;
  localparam logic [4:0] S_R_NCHK = 5'd13;
  localparam logic [4:0] S_R_NRD  = 5'd14;
  localparam logic [4:0] S_R_NEV  = 5'd15;
  localparam logic [4:0] S_R_FIN  = 5'd16;
  localparam logic [4:0] S_R_LNK  = 5'd17;
  localparam logic [4:0] S_RESP   = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

  always_comb begin
    state_next      = state;
    dcmd            = '0;
    dcmd.ptr_sel    = ffha_pkg::PTR_HOLD;
    dcmd.wr         = ffha_pkg::WR_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          dcmd.load  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.alloc_cmd) begin
          if (stat.want_zero) begin
            dcmd.res_set = 1'b1;
            state_next   = S_RESP;
          end else if (!stat.ready) begin
            state_next = S_SETUP;
          end else begin
            state_next = S_A_RD;
          end
        end else if (stat.rel_bad) begin
          dcmd.res_set = 1'b1;
          state_next   = S_RESP;
        end else begin
          state_next = S_W_RD;
        end
      end
      S_SETUP: begin
        dcmd.wr        = ffha_pkg::WR_SETUP;
        dcmd.set_ready = 1'b1;
        state_next     = S_A_RD;
      end
      S_A_RD: state_next = S_A_EV;
      S_A_EV: begin
        if (stat.fit) begin
          dcmd.cap   = 1'b1;
          state_next = S_A_W1;
        end else if (stat.rnext_seg) begin
          dcmd.ptr_sel = ffha_pkg::PTR_NEXT;
          state_next   = S_A_RD;
        end else begin
          dcmd.res_set = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_A_W1: begin
        dcmd.wr = ffha_pkg::WR_USED;
        if (stat.split) begin
          state_next = S_A_W2;
        end else begin
          dcmd.res_set = 1'b1;
          dcmd.res_ok  = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_A_W2: begin
        dcmd.wr = ffha_pkg::WR_NEW;
        if (stat.cnext_seg) begin
          state_next = S_A_W3;
        end else begin
          dcmd.res_set = 1'b1;
          dcmd.res_ok  = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_A_W3: begin
        dcmd.wr      = ffha_pkg::WR_LINK_A;
        dcmd.res_set = 1'b1;
        dcmd.res_ok  = 1'b1;
        state_next   = S_RESP;
      end
      S_W_RD: state_next = S_W_EV;
      S_W_EV: begin
        if (stat.hit) begin
          if (stat.rfree) begin
            dcmd.res_set = 1'b1;
            state_next   = S_RESP;
          end else begin
            dcmd.cap   = 1'b1;
            state_next = S_R_FREE;
          end
        end else if (stat.past || !stat.rnext_seg) begin
          dcmd.res_set = 1'b1;
          state_next   = S_RESP;
        end else begin
          dcmd.ptr_sel = ffha_pkg::PTR_NEXT;
          state_next   = S_W_RD;
        end
      end
      S_R_FREE: begin
        dcmd.wr = ffha_pkg::WR_FREE;
        if (stat.cprev_seg) begin
          dcmd.ptr_sel = ffha_pkg::PTR_PREV;
          state_next   = S_R_PRD;
        end else begin
          state_next = S_R_NCHK;
        end
      end
      S_R_PRD: state_next = S_R_PEV;
      S_R_PEV: begin
        dcmd.merge_prev = stat.rfree;
        state_next      = S_R_NCHK;
      end
      S_R_NCHK: begin
        if (stat.cnext_seg) begin
          dcmd.ptr_sel = ffha_pkg::PTR_CNEXT;
          state_next   = S_R_NRD;
        end else begin
          state_next = S_R_FIN;
        end
      end
      S_R_NRD: state_next = S_R_NEV;
      S_R_NEV: begin
        if (stat.rfree) begin
          dcmd.merge_next = 1'b1;
          state_next      = S_R_NCHK;
        end else begin
          state_next = S_R_FIN;
        end
      end
      S_R_FIN: begin
        dcmd.wr = ffha_pkg::WR_FIN;
        if (stat.cnext_seg) begin
          state_next = S_R_LNK;
        end else begin
          dcmd.res_set = 1'b1;
          dcmd.res_ok  = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_R_LNK: begin
        dcmd.wr      = ffha_pkg::WR_LINK_R;
        dcmd.res_set = 1'b1;
        dcmd.res_ok  = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### src/ffha_dp.sv
// ffha_dp: header memory, walk pointer, segment registers and result registers
// depends on ffha_pkg; commanded by ffha_ctrl
module ffha_dp #(
  parameter int HEAP_WORDS   = ffha_pkg::HEAP_WORDS_DEF,
  parameter int HEADER_WORDS = ffha_pkg::HEADER_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd,
  input  logic [9:0]         alloc_size,
  input  logic [9:0]         free_addr,
  input  ffha_pkg::dp_cmd_t  dcmd,
  output ffha_pkg::dp_stat_t stat,
  output logic               ok,
  output logic [9:0]         addr
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int LW = $clog2(HEAP_WORDS + 1);
  localparam int CW = ((LW > 11) ? LW : 11) + 1;
  localparam logic [LW-1:0] NONE = LW'(HEAP_WORDS);
  localparam logic [CW-1:0] HDR  = CW'(HEADER_WORDS);
  localparam logic [CW-1:0] HEAP = CW'(HEAP_WORDS);

  logic          seg_free [HEAP_WORDS];
  logic [LW-1:0] seg_prev [HEAP_WORDS];
  logic [LW-1:0] seg_next [HEAP_WORDS];
  logic [LW-1:0] seg_size [HEAP_WORDS];

  logic          cmd_r;
  logic [9:0]    want;
  logic [9:0]    target;
  logic          ready;
  logic [LW-1:0] ptr;
  logic [LW-1:0] cur_h;
  logic [LW-1:0] cur_prev;
  logic [LW-1:0] cur_next;
  logic [LW-1:0] cur_size;
  logic          rd_free;
  logic [LW-1:0] rd_prev;
  logic [LW-1:0] rd_next;
  logic [LW-1:0] rd_size;

  logic          we_free;
  logic          we_prev;
  logic          we_next;
  logic          we_size;
  logic [LW-1:0] waddr;
  logic          wd_free;
  logic [LW-1:0] wd_prev;
  logic [LW-1:0] wd_next;
  logic [LW-1:0] wd_size;
  logic [CW-1:0] nw;
  logic          split;

  assign nw    = CW'(cur_h) + HDR + CW'(want);
  assign split = (CW'(cur_size) > CW'(want) + HDR) && (nw < HEAP);

  assign stat.alloc_cmd = (cmd_r == ffha_pkg::CMD_ALLOC);
  assign stat.want_zero = (want == 10'd0);
  assign stat.ready     = ready;
  assign stat.rel_bad   = !ready || (CW'(target) < HDR) || (target == 10'd0);
  assign stat.fit       = rd_free && (CW'(rd_size) >= CW'(want));
  assign stat.split     = split;
  assign stat.hit       = (CW'(ptr) + HDR == CW'(target));
  assign stat.past      = (CW'(ptr) + HDR > CW'(target));
  assign stat.rfree     = rd_free;
  assign stat.rnext_seg = (rd_next < NONE);
  assign stat.cprev_seg = (cur_prev < NONE);
  assign stat.cnext_seg = (cur_next < NONE);

  // header write decode
  always_comb begin
    we_free = 1'b0;
    we_prev = 1'b0;
    we_next = 1'b0;
    we_size = 1'b0;
    waddr   = cur_h;
    wd_free = 1'b1;
    wd_prev = cur_h;
    wd_next = cur_next;
    wd_size = cur_size;
    case (dcmd.wr)
      ffha_pkg::WR_SETUP: begin
        waddr   = '0;
        we_free = 1'b1;
        we_prev = 1'b1;
        we_next = 1'b1;
        we_size = 1'b1;
        wd_prev = NONE;
        wd_next = NONE;
        wd_size = LW'(HEAP - HDR);
      end
      ffha_pkg::WR_USED: begin
        we_free = 1'b1;
        wd_free = 1'b0;
        we_next = split;
        we_size = split;
        wd_next = LW'(nw);
        wd_size = LW'(want);
      end
      ffha_pkg::WR_NEW: begin
        waddr   = LW'(nw);
        we_free = 1'b1;
        we_prev = 1'b1;
        we_next = 1'b1;
        we_size = 1'b1;
        wd_size = LW'(CW'(cur_size) - CW'(want) - HDR);
      end
      ffha_pkg::WR_LINK_A: begin
        waddr   = cur_next;
        we_prev = 1'b1;
        wd_prev = LW'(nw);
      end
      ffha_pkg::WR_FREE: begin
        we_free = 1'b1;
      end
      ffha_pkg::WR_FIN: begin
        we_free = 1'b1;
        we_next = 1'b1;
        we_size = 1'b1;
      end
      ffha_pkg::WR_LINK_R: begin
        waddr   = cur_next;
        we_prev = 1'b1;
      end
      default: begin
        we_free = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_free) seg_free[waddr[AW-1:0]] <= wd_free;
    if (we_prev) seg_prev[waddr[AW-1:0]] <= wd_prev;
    if (we_next) seg_next[waddr[AW-1:0]] <= wd_next;
    if (we_size) seg_size[waddr[AW-1:0]] <= wd_size;
    rd_free <= seg_free[ptr[AW-1:0]];
    rd_prev <= seg_prev[ptr[AW-1:0]];
    rd_next <= seg_next[ptr[AW-1:0]];
    rd_size <= seg_size[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
    end else if (dcmd.set_ready) begin
      ready <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      cmd_r  <= cmd;
      want   <= alloc_size;
      target <= free_addr;
      ptr    <= '0;
    end else begin
      case (dcmd.ptr_sel)
        ffha_pkg::PTR_NEXT:  ptr <= rd_next;
        ffha_pkg::PTR_PREV:  ptr <= cur_prev;
        ffha_pkg::PTR_CNEXT: ptr <= cur_next;
        default:             ptr <= ptr;
      endcase
    end
    if (dcmd.cap) begin
      cur_h    <= ptr;
      cur_prev <= rd_prev;
      cur_next <= rd_next;
      cur_size <= rd_size;
    end else if (dcmd.merge_prev) begin
      cur_h    <= ptr;
      cur_size <= LW'(CW'(rd_size) + CW'(cur_size) + HDR);
    end else if (dcmd.merge_next) begin
      cur_next <= rd_next;
      cur_size <= LW'(CW'(cur_size) + CW'(rd_size) + HDR);
    end
    if (dcmd.res_set) begin
      ok   <= dcmd.res_ok;
      addr <= (dcmd.res_ok && stat.alloc_cmd) ? 10'(CW'(cur_h) + HDR) : 10'd0;
    end
  end

endmodule

### src/first_fit_heap_allocator_unit.sv
// first_fit_heap_allocator_unit: first-fit heap allocator with coalescing
// allocate: heap setup on first use, a first-fit header walk, then 1 to 3 header writes on a fit
// release: header walk to the target; on success the segment is freed, merged with a free previous segment
//   and with each free next segment, and relinked to a used next segment
// one item at a time, next item taken the cycle after done; receiver cannot stall
// sync reset clears the controller and the heap setup flag; headers are written on use
module first_fit_heap_allocator_unit #(
  parameter int HEAP_WORDS   = ffha_pkg::HEAP_WORDS_DEF,
  parameter int HEADER_WORDS = ffha_pkg::HEADER_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cmd,
  input  logic [9:0] alloc_size,
  input  logic [9:0] free_addr,
  output logic       done,
  output logic       ok,
  output logic [9:0] addr
);

  ffha_pkg::dp_cmd_t  dcmd;
  ffha_pkg::dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .dcmd  (dcmd),
    .busy  (busy),
    .done  (done)
  );

  ffha_dp #(
    .HEAP_WORDS   (HEAP_WORDS),
    .HEADER_WORDS (HEADER_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .alloc_size (alloc_size),
    .free_addr  (free_addr),
    .dcmd       (dcmd),
    .stat       (stat),
    .ok         (ok),
    .addr       (addr)
  );

endmodule

### src/ffha_checker.sv
// ffha_checker: port-level checks of the allocator's handshake and results
// depends on nothing; bound to first_fit_heap_allocator_unit below
module ffha_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       ok,
  input logic [9:0] addr
);

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> (!busy && !done))
    else $error("not idle after reset");

  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item taken but not busy");

  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst) (done && !ok) |-> (addr == 10'd0))
    else $error("failed item with nonzero address");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .ok    (ok),
  .addr  (addr)
);

### test/tb_first_fit_heap_allocator_unit.sv
// tb_first_fit_heap_allocator_unit: self-checking bench for the first-fit heap allocator
// predicts each allocate/release result from its own segment chain model and checks ok/addr
// depends on ffha_pkg and first_fit_heap_allocator_unit
class heap_scoreboard;
  localparam int WORDS = 1024;
  localparam int HDR = 4;
  localparam int NONE = WORDS;

  bit ready;
  bit sfree[WORDS];
  int sprev[WORDS];
  int snext[WORDS];
  int ssize[WORDS];
  bit exp_ok[$];
  logic [9:0] exp_addr[$];
  int errors;
  int live[$];

  function void clear();
    ready = 0;
    exp_ok.delete();
    exp_addr.delete();
    live.delete();
    errors = 0;
  endfunction

  function void join_next(int a, int b);
    int nx;
    nx = snext[b];
    snext[a] = nx;
    if (nx < WORDS) sprev[nx] = a;
    ssize[a] = ssize[a] + ssize[b] + HDR;
  endfunction

  function bit allocate(int want, output int where);
    int c;
    int steps;
    int nw;
    c = 0;
    steps = 0;
    where = 0;
    if (want == 0) return 0;
    if (!ready) begin
      sfree[0] = 1; sprev[0] = NONE; snext[0] = NONE; ssize[0] = WORDS - HDR; ready = 1;
    end
    while (c < WORDS && steps < WORDS) begin
      if (sfree[c] && ssize[c] >= want) begin
        sfree[c] = 0;
        nw = c + HDR + want;
        if (ssize[c] > want + HDR && nw < WORDS) begin
          ssize[nw] = ssize[c] - want - HDR;
          sfree[nw] = 1;
          sprev[nw] = c;
          snext[nw] = snext[c];
          snext[c] = nw;
          ssize[c] = want;
          if (snext[nw] < WORDS) sprev[snext[nw]] = nw;
        end
        where = (c + HDR) & 10'h3ff;
        return 1;
      end
      c = snext[c];
      steps++;
    end
    return 0;
  endfunction

  function bit release_seg(int pay);
    int target;
    int c;
    int steps;
    int p;
    int n;
    int guard;
    c = 0;
    steps = 0;
    guard = 0;
    if (!ready || pay < HDR) return 0;
    target = pay - HDR;
    while (c < WORDS && steps < WORDS) begin
      if (c == target) begin
        if (sfree[c]) return 0;
        sfree[c] = 1;
        p = sprev[c];
        if (p < WORDS && sfree[p]) begin
          join_next(p, c);
          c = p;
        end
        n = snext[c];
        while (n < WORDS && sfree[n] && guard < WORDS) begin
          join_next(c, n);
          n = snext[c];
          guard++;
        end
        return 1;
      end
      if (c > target) return 0;
      c = snext[c];
      steps++;
    end
    return 0;
  endfunction

  function void note_item(bit op, int size, int faddr);
    bit r;
    int where;
    int i;
    where = 0;
    if (op == ffha_pkg::CMD_ALLOC) begin
      r = allocate(size, where);
      if (r) live.push_back(where);
    end else begin
      r = release_seg(faddr);
      if (r) begin
        for (i = 0; i < live.size(); i++)
          if (live[i] == faddr) begin
            live.delete(i);
            break;
          end
      end
    end
    exp_ok.push_back(r);
    exp_addr.push_back(r ? where[9:0] : 10'd0);
  endfunction

  function void check_result(bit got_ok, logic [9:0] got_addr);
    bit eo;
    logic [9:0] ea;
    if (exp_ok.size() == 0) begin
      $display("%0t: unexpected result ok=%0d addr=%0d", $time, got_ok, got_addr);
      errors++;
      return;
    end
    eo = exp_ok.pop_front();
    ea = exp_addr.pop_front();
    if (got_ok !== eo) begin
      $display("%0t: ok expected %0d actual %0d", $time, eo, got_ok);
      errors++;
    end
    if (got_addr !== ea) begin
      $display("%0t: addr expected %0d actual %0d", $time, ea, got_addr);
      errors++;
    end
  endfunction
endclass

module tb_first_fit_heap_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic cmd = ffha_pkg::CMD_ALLOC;
  logic [9:0] alloc_size = '0;
  logic [9:0] free_addr = '0;
  logic done;
  logic ok;
  logic [9:0] addr;
  heap_scoreboard heap_sb;
  longint cycles = 0;
  bit quiet = 0;

  first_fit_heap_allocator_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .alloc_size(alloc_size), .free_addr(free_addr), .done(done), .ok(ok), .addr(addr)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) heap_sb.check_result(ok, addr);
    if (cycles > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue(bit op, int size, int faddr);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    cmd <= op;
    alloc_size <= size[9:0];
    free_addr <= faddr[9:0];
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    heap_sb.note_item(op, size, faddr);
    @(negedge clk);
    start <= 0;
    @(negedge clk);
  endtask

  task automatic random_item();
    int k;
    int sz;
    int fa;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 64);
      issue(ffha_pkg::CMD_ALLOC, sz, $urandom_range(0, 1023));
    end else if (k < 85 && heap_sb.live.size() > 0) begin
      fa = heap_sb.live[$urandom_range(0, heap_sb.live.size() - 1)];
      issue(ffha_pkg::CMD_RELEASE, $urandom_range(0, 1023), fa);
    end else begin
      issue(ffha_pkg::CMD_RELEASE, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    heap_sb = new();
    heap_sb.clear();
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // release before setup, zero size, null, too large, double and bad releases, merges
    issue(ffha_pkg::CMD_RELEASE, 0, 4);
    issue(ffha_pkg::CMD_ALLOC, 0, 0);
    issue(ffha_pkg::CMD_RELEASE, 1023, 0);
    issue(ffha_pkg::CMD_ALLOC, 1023, 1023);
    issue(ffha_pkg::CMD_ALLOC, 1020, 0);
    issue(ffha_pkg::CMD_RELEASE, 0, 4);
    issue(ffha_pkg::CMD_ALLOC, 10, 0);
    issue(ffha_pkg::CMD_ALLOC, 20, 0);
    issue(ffha_pkg::CMD_ALLOC, 1, 0);
    issue(ffha_pkg::CMD_ALLOC, 1016, 0);
    issue(ffha_pkg::CMD_RELEASE, 0, 18);
    issue(ffha_pkg::CMD_RELEASE, 0, 18);
    issue(ffha_pkg::CMD_RELEASE, 0, 3);
    issue(ffha_pkg::CMD_RELEASE, 0, 7);
    issue(ffha_pkg::CMD_RELEASE, 0, 1023);
    issue(ffha_pkg::CMD_RELEASE, 0, 4);
    issue(ffha_pkg::CMD_ALLOC, 5, 0);
    issue(ffha_pkg::CMD_ALLOC, 5, 0);
    issue(ffha_pkg::CMD_RELEASE, 0, 42);
    issue(ffha_pkg::CMD_ALLOC, 512, 0);
    issue(ffha_pkg::CMD_ALLOC, 1016, 0);
    for (int i = 0; i < 850; i++) begin
      quiet = (i > 700);
      random_item();
    end
    while (heap_sb.exp_ok.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (heap_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
